/* hdl/sbpq_pkg.sv */
// Shared types and constants for the sorted byte priority queue.
package sbpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int HELD_W   = 5;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct packed {
    logic              func;
    logic signed [7:0] value;
  } in_t;

  typedef struct packed {
    logic signed [7:0]  removed_value;
    logic               was_empty;
    logic               dropped;
    logic               now_empty;
    logic [HELD_W-1:0]  held;
  } out_t;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic signed [7:0] value;
  } cell_ctrl_t;

endpackage

/* hdl/sbpq_cell.sv */
// One storage cell of the sorted chain: keep, take new value, or shift.
module sbpq_cell (
  input  logic                  clk,
  input  sbpq_pkg::cell_ctrl_t  ctrl,
  input  logic                  occupied,
  input  logic                  left_gt,
  input  logic signed [7:0]     left_val,
  input  logic signed [7:0]     right_val,
  output logic                  gt,
  output logic signed [7:0]     val
);

  logic signed [7:0] val_r;
  logic signed [7:0] val_nxt;

  // new value belongs after this cell
  assign gt  = occupied && (ctrl.value > val_r);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (!gt) begin
        val_nxt = left_gt ? ctrl.value : left_val;
      end
    end else if (ctrl.rem) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* hdl/sorted_byte_priority_queue.sv */
// Top level of the sorted byte priority queue: cell chain, count and result register.
//
// A shift-register priority queue of CAPACITY signed bytes kept in ascending
// order. Every cell compares the incoming value against its own contents in
// the same cycle, so an insert or a remove-smallest updates the whole chain at
// once; a new request is taken every cycle as long as the result register is
// empty or being drained, and its result is registered and appears in the
// cycle after acceptance. Equal values are ordered newest first. Removing from
// an empty queue returns 0 with was_empty set; inserting into a full queue
// leaves it unchanged with dropped set. held reports the count after the
// request. No clearing pass is needed after reset.
module sorted_byte_priority_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sbpq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sbpq_pkg::out_t out_data
);

  logic                       out_valid_r;
  sbpq_pkg::out_t             out_r;
  sbpq_pkg::out_t             out_nxt;
  logic [sbpq_pkg::CNT_W-1:0] count_r;
  logic [sbpq_pkg::CNT_W-1:0] count_nxt;
  logic                       accept;
  logic                       empty;
  logic                       full;
  sbpq_pkg::cell_ctrl_t       ctrl;

  logic                       gt  [sbpq_pkg::CAPACITY];
  logic signed [7:0]          val [sbpq_pkg::CAPACITY];

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign empty     = (count_r == '0);
  assign full      = (count_r == sbpq_pkg::CNT_W'(sbpq_pkg::CAPACITY));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ctrl.ins   = accept && (in_data.func == sbpq_pkg::FUNC_INSERT) && !full;
  assign ctrl.rem   = accept && (in_data.func == sbpq_pkg::FUNC_REMOVE) && !empty;
  assign ctrl.value = in_data.value;

  for (genvar i = 0; i < sbpq_pkg::CAPACITY; i++) begin : g_cell
    logic              occ;
    logic              lgt;
    logic signed [7:0] lval;
    logic signed [7:0] rval;

    assign occ = (sbpq_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign lgt  = 1'b1;
      assign lval = val[i];
    end else begin : g_mid
      assign lgt  = gt[i-1];
      assign lval = val[i-1];
    end

    if (i == sbpq_pkg::CAPACITY - 1) begin : g_last
      assign rval = val[i];
    end else begin : g_inner
      assign rval = val[i+1];
    end

    sbpq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ),
      .left_gt   (lgt),
      .left_val  (lval),
      .right_val (rval),
      .gt        (gt[i]),
      .val       (val[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_nxt.removed_value = ctrl.rem ? val[0] : 8'sd0;
    out_nxt.was_empty     = (in_data.func == sbpq_pkg::FUNC_REMOVE) && empty;
    out_nxt.dropped       = (in_data.func == sbpq_pkg::FUNC_INSERT) && full;
    out_nxt.now_empty     = (count_nxt == '0);
    out_nxt.held          = sbpq_pkg::HELD_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

endmodule
